/* hw/rtl/nfcc_pkg.sv */
// ----------------------------------------------------------------------------
// NOR flash command controller package
// Shared types, constants and helper functions.
// ----------------------------------------------------------------------------
package nfcc_pkg;

    localparam int MemBytes  = 2097152;
    localparam int AddrW     = 21;
    localparam int MaxBlocks = 35;
    localparam int BlkW      = 6;
    localparam int QDepth    = 2;

    localparam logic [1:0] OP_READ    = 2'd0;
    localparam logic [1:0] OP_WRITE   = 2'd1;
    localparam logic [1:0] OP_PRELOAD = 2'd2;
    localparam logic [1:0] OP_NOP     = 2'd3;

    localparam logic [14:0] UNLOCK_A1 = 15'h5555;
    localparam logic [14:0] UNLOCK_A2 = 15'h2aaa;
    localparam logic [7:0] D_UNLOCK1  = 8'haa;
    localparam logic [7:0] D_UNLOCK2  = 8'h55;
    localparam logic [7:0] D_ERASE    = 8'h80;
    localparam logic [7:0] D_PROTECT  = 8'h9a;
    localparam logic [7:0] D_READID   = 8'h90;
    localparam logic [7:0] D_PROGRAM  = 8'ha0;
    localparam logic [7:0] D_RESET    = 8'hf0;
    localparam logic [7:0] D_CHIP     = 8'h10;
    localparam logic [7:0] D_SECTOR   = 8'h30;
    localparam logic [7:0] VENDOR_ID  = 8'h98;

    localparam logic [1:0] MODE_READ   = 2'd0;
    localparam logic [1:0] MODE_INDEX  = 2'd1;
    localparam logic [1:0] MODE_READID = 2'd2;
    localparam logic [1:0] MODE_WRITE  = 2'd3;

    // Work kinds handed from the front to the back.
    typedef enum logic [2:0] {
        K_READ   = 3'd0,
        K_ID     = 3'd1,
        K_POKE   = 3'd2,
        K_PROG   = 3'd3,
        K_ERASE  = 3'd4,
        K_CHIP   = 3'd5,
        K_NONE   = 3'd6
    } kind_t;

    typedef struct packed {
        kind_t           kind;
        logic [AddrW-1:0] addr;
        logic [7:0]      data;
        logic [BlkW-1:0] blk;
    } job_t;

    function automatic logic [1:0] sel_eff(input logic [1:0] s);
        return (s == 2'd3) ? 2'd2 : s;
    endfunction

    function automatic logic [AddrW-1:0] size_mask(input logic [1:0] s);
        return AddrW'((32'd524288 << sel_eff(s)) - 32'd1);
    endfunction

    function automatic logic [BlkW-1:0] full_blocks(input logic [1:0] s);
        return BlkW'((32'd8 << sel_eff(s)) - 32'd1);
    endfunction

    function automatic logic [BlkW-1:0] find_block(input logic [1:0] s,
                                                   input logic [AddrW-1:0] a);
        logic [AddrW-1:0] top;
        logic [15:0]      r;
        logic [BlkW-1:0]  base;
        top  = size_mask(s) - AddrW'(65535);
        base = full_blocks(s);
        r    = a[15:0];
        if (a < top) return BlkW'(a[AddrW-1:16]);
        if (r < 16'd32768) return base;
        if (r < 16'd40960) return base + BlkW'(1);
        if (r < 16'd49152) return base + BlkW'(2);
        return base + BlkW'(3);
    endfunction

    // Start address and length (in bytes) of a block.
    function automatic logic [AddrW-1:0] blk_off(input logic [1:0] s,
                                                 input logic [BlkW-1:0] i);
        logic [BlkW-1:0] base;
        logic [1:0]      k;
        logic [AddrW-1:0] top;
        base = full_blocks(s);
        k    = 2'(i - base);
        top  = size_mask(s) - AddrW'(65535);
        if (i < base) return {i[4:0], 16'd0};
        case (k)
            2'd0:    return top;
            2'd1:    return top + AddrW'(32768);
            2'd2:    return top + AddrW'(40960);
            default: return top + AddrW'(49152);
        endcase
    endfunction

    function automatic logic [16:0] blk_len(input logic [1:0] s,
                                            input logic [BlkW-1:0] i);
        logic [1:0] k;
        k = 2'(i - full_blocks(s));
        if (i < full_blocks(s)) return 17'd65536;
        case (k)
            2'd0:    return 17'd32768;
            2'd1:    return 17'd8192;
            2'd2:    return 17'd8192;
            default: return 17'd16384;
        endcase
    endfunction

endpackage

/* hw/rtl/nfcc_front.sv */
// ----------------------------------------------------------------------------
// NOR flash command front end
// Tracks the unlock sequence and turns each request into a job for the back.
// ----------------------------------------------------------------------------
module nfcc_front import nfcc_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [1:0]       size_sel,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       opcode,
    input  logic [AddrW-1:0] bus_address,
    input  logic [7:0]       bus_data,
    output logic             job_valid,
    input  logic             job_ready,
    output job_t             job
);
    logic [1:0] mode_reg, mode_next;
    logic [2:0] stage_reg, stage_next;
    logic [AddrW-1:0] a;
    logic [14:0] a15;
    kind_t k;

    assign in_ready  = job_ready;
    assign job_valid = in_valid;
    assign a   = bus_address & size_mask(size_sel);
    assign a15 = a[14:0];

    always_comb begin
        mode_next  = mode_reg;
        stage_next = stage_reg;
        k          = K_NONE;
        case (opcode)
            OP_READ:    k = (mode_reg == MODE_READID) ? K_ID : K_READ;
            OP_PRELOAD: k = K_POKE;
            OP_WRITE: begin
                mode_next  = MODE_READ;
                stage_next = 3'd0;
                if (mode_reg == MODE_WRITE) begin
                    k = K_PROG;
                end else if (bus_data == D_RESET) begin
                    k = K_NONE;
                end else if ((stage_reg == 3'd0 && a15 == UNLOCK_A1 && bus_data == D_UNLOCK1)
                          || (stage_reg == 3'd1 && a15 == UNLOCK_A2 && bus_data == D_UNLOCK2)
                          || (stage_reg == 3'd2 && a15 == UNLOCK_A1
                              && (bus_data == D_ERASE || bus_data == D_PROTECT))
                          || (stage_reg == 3'd3 && a15 == UNLOCK_A1 && bus_data == D_UNLOCK1)
                          || (stage_reg == 3'd4 && a15 == UNLOCK_A2 && bus_data == D_UNLOCK2))
                begin
                    mode_next  = MODE_INDEX;
                    stage_next = stage_reg + 3'd1;
                end else if (stage_reg == 3'd2 && a15 == UNLOCK_A1 && bus_data == D_READID) begin
                    mode_next  = MODE_READID;
                    stage_next = stage_reg;
                end else if (stage_reg == 3'd2 && a15 == UNLOCK_A1 && bus_data == D_PROGRAM) begin
                    mode_next  = MODE_WRITE;
                    stage_next = stage_reg;
                end else if (stage_reg == 3'd5) begin
                    // Protect travels as an erase job; the back end tells them
                    // apart by the command byte.
                    if (a15 == UNLOCK_A1 && bus_data == D_CHIP) k = K_CHIP;
                    else if (bus_data == D_SECTOR) k = K_ERASE;
                    else if (bus_data == D_PROTECT) k = K_ERASE;
                end
            end
            default: k = K_NONE;
        endcase
    end

    always_comb begin
        job.kind = k;
        job.addr = a;
        job.data = bus_data;
        job.blk  = find_block(size_sel, a);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_READ;
            stage_reg <= 3'd0;
        end else if (in_valid && in_ready) begin
            mode_reg  <= mode_next;
            stage_reg <= stage_next;
        end
    end
endmodule

/* hw/rtl/nfcc_queue.sv */
// ----------------------------------------------------------------------------
// NOR flash job queue
// Short FIFO between the command front end and the array back end.
// ----------------------------------------------------------------------------
module nfcc_queue import nfcc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  job_t in_job,
    output logic out_valid,
    input  logic out_ready,
    output job_t out_job
);
    job_t slot_reg [QDepth];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic push, pop;

    assign in_ready  = (cnt_reg != 2'(QDepth));
    assign out_valid = (cnt_reg != 2'd0);
    assign out_job   = slot_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wp_reg] <= in_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

/* hw/rtl/nfcc_back.sv */
// ----------------------------------------------------------------------------
// NOR flash array back end
// Holds the array and protection bits and carries out each job.
// ----------------------------------------------------------------------------
module nfcc_back import nfcc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [1:0]  size_sel,
    input  logic        job_valid,
    output logic        job_ready,
    input  job_t        job,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_rdata,
    output logic        m_dirty
);
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RD    = 5'b00010,
        S_PROG  = 5'b00100,
        S_WIPE  = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    logic [7:0] mem [MemBytes];
    logic [7:0] rd_q;
    logic [MaxBlocks-1:0] wr_en_reg, wr_en_next;
    state_t state_reg, state_next;
    job_t   job_reg;
    logic   dirty_reg, dirty_next;
    logic [7:0] rdata_reg, rdata_next;
    logic [BlkW-1:0]  blk_reg, blk_next;
    logic [AddrW-1:0] wa_reg, wa_next;
    logic [16:0]      left_reg, left_next;
    logic             chip_reg, chip_next;
    logic             mwe;
    logic [AddrW-1:0] maddr;
    logic [7:0]       mwd;
    logic [7:0]       idv, nv;
    logic             ok_blk;
    logic [BlkW-1:0]  nblk;

    assign job_ready = (state_reg == S_IDLE);
    assign m_valid   = (state_reg == S_OUT);
    assign m_rdata   = rdata_reg;
    assign m_dirty   = dirty_reg;

    always_comb begin
        case (job.addr[13:0])
            14'd0: idv = VENDOR_ID;
            14'd1: idv = (sel_eff(size_sel) == 2'd0) ? 8'hab :
                         (sel_eff(size_sel) == 2'd1) ? 8'h2c : 8'h2f;
            14'd2: idv = 8'h02;
            14'd3: idv = 8'h80;
            default: idv = 8'hff;
        endcase
    end

    assign nv = rd_q & job_reg.data;
    assign ok_blk = (blk_reg < BlkW'(MaxBlocks)) && wr_en_reg[blk_reg[5:0]];
    assign nblk = blk_reg + BlkW'(1);

    always_comb begin
        state_next = state_reg;
        wr_en_next = wr_en_reg;
        dirty_next = dirty_reg;
        rdata_next = rdata_reg;
        blk_next   = blk_reg;
        wa_next    = wa_reg;
        left_next  = left_reg;
        chip_next  = chip_reg;
        mwe   = 1'b0;
        maddr = job.addr;
        mwd   = job.data;
        case (state_reg)
            S_IDLE: begin
                if (job_valid) begin
                    rdata_next = 8'd0;
                    blk_next   = job.blk;
                    case (job.kind)
                        K_READ: state_next = S_RD;
                        K_ID: begin
                            rdata_next = idv;
                            state_next = S_OUT;
                        end
                        K_POKE: begin
                            mwe = 1'b1;
                            state_next = S_OUT;
                        end
                        K_PROG: state_next = S_PROG;
                        K_ERASE: begin
                            if (job.data == D_PROTECT) begin
                                if (job.blk < BlkW'(MaxBlocks)
                                    && wr_en_reg[job.blk]) begin
                                    wr_en_next[job.blk] = 1'b0;
                                    dirty_next = 1'b1;
                                end
                                state_next = S_OUT;
                            end else begin
                                chip_next  = 1'b0;
                                wa_next    = blk_off(size_sel, job.blk);
                                left_next  = blk_len(size_sel, job.blk);
                                state_next = S_WIPE;
                            end
                        end
                        K_CHIP: begin
                            chip_next  = 1'b1;
                            blk_next   = '0;
                            wa_next    = '0;
                            left_next  = blk_len(size_sel, '0);
                            state_next = S_WIPE;
                        end
                        default: state_next = S_OUT;
                    endcase
                end
            end
            S_RD: begin
                rdata_next = rd_q;
                state_next = S_OUT;
            end
            S_PROG: begin
                maddr = job_reg.addr;
                mwd   = nv;
                if (ok_blk && nv != rd_q) begin
                    mwe = 1'b1;
                    dirty_next = 1'b1;
                end
                state_next = S_OUT;
            end
            S_WIPE: begin
                maddr = wa_reg;
                mwd   = 8'hff;
                if (ok_blk) begin
                    mwe = 1'b1;
                    dirty_next = 1'b1;
                end
                wa_next   = wa_reg + AddrW'(1);
                left_next = left_reg - 17'd1;
                if (left_reg == 17'd1) begin
                    if (chip_reg && nblk != full_blocks(size_sel) + BlkW'(4)) begin
                        blk_next  = nblk;
                        wa_next   = blk_off(size_sel, nblk);
                        left_next = blk_len(size_sel, nblk);
                    end else begin
                        state_next = S_OUT;
                    end
                end
                if (!ok_blk && !(left_reg == 17'd1)) begin
                    // Protected or absent block: skip to its last byte.
                    left_next = 17'd1;
                end
            end
            S_OUT: if (m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mwe) mem[maddr] <= mwd;
        rd_q <= mem[maddr];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && job_valid) job_reg <= job;
        rdata_reg <= rdata_next;
        blk_reg   <= blk_next;
        wa_reg    <= wa_next;
        left_reg  <= left_next;
        chip_reg  <= chip_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            wr_en_reg <= '1;
            dirty_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            wr_en_reg <= wr_en_next;
            dirty_reg <= dirty_next;
        end
    end
endmodule

/* hw/rtl/nor_flash_command_controller_unit.sv */
// ----------------------------------------------------------------------------
// NOR flash command controller
// Byte-wide NOR flash with an unlock command interface and block protection.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// s_axis    in   tdata: opcode[1:0], bus_address[22:2], bus_data[30:23]
// m_axis    out  tdata: read_data[7:0], dirty[8]
// apb       in   reg 0: size_select[1:0]
// Reads and programs pass through a read or program state before the result
// state; other requests except erases go straight to it. Results wait for m_tready.
// Block erase writes one byte a cycle; erase all walks every block. The front
// keeps taking requests while the queue has room.
// Reset clears the command state and protection; array contents stay undefined.
module nor_flash_command_controller_unit import nfcc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // opcode, bus_address, bus_data
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // read_data, dirty
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [1:0] size_reg;
    logic fq_valid, fq_ready, qb_valid, qb_ready;
    job_t fq_job, qb_job;
    logic [7:0] rdata;
    logic dirty;

    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? {30'd0, size_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) size_reg <= 2'd2;
        else if (psel && penable && pwrite && paddr == 1'b0) size_reg <= pwdata[1:0];
    end

    nfcc_front u_front (
        .aclk, .aresetn, .size_sel(size_reg),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .opcode(s_tdata[1:0]), .bus_address(s_tdata[22:2]), .bus_data(s_tdata[30:23]),
        .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
    );

    nfcc_queue u_queue (
        .aclk, .aresetn,
        .in_valid(fq_valid), .in_ready(fq_ready), .in_job(fq_job),
        .out_valid(qb_valid), .out_ready(qb_ready), .out_job(qb_job)
    );

    nfcc_back u_back (
        .aclk, .aresetn, .size_sel(size_reg),
        .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
        .m_valid(m_tvalid), .m_ready(m_tready), .m_rdata(rdata), .m_dirty(dirty)
    );

    assign m_tdata = {7'd0, dirty, rdata};
endmodule

/* test/nfcc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NOR flash command controller checker
// Watches the request, result and register ports, keeps its own image of the
// flash array, protection bits and command state, and compares every result
// with the predicted read byte and dirty flag in order.
// ----------------------------------------------------------------------------
module nfcc_checker import nfcc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // opcode, bus_address, bus_data
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // read_data, dirty
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [7:0] rd;
        logic       dirty;
    } access_result_t;

    localparam int TopOff[4] = '{0, 32768, 40960, 49152};
    localparam int TopLen[4] = '{32768, 8192, 8192, 16384};

    logic [7:0]     flash_img [0:MemBytes-1];
    logic           writable [0:MaxBlocks-1];
    logic [1:0]     mode;
    logic [2:0]     stage;
    logic           dirty_q;
    logic [1:0]     size_sel;
    access_result_t result_q [$];

    function automatic int eff_sel();
        return (size_sel == 2'd3) ? 2 : int'(size_sel);
    endfunction

    function automatic int dev_bytes();
        return 524288 << eff_sel();
    endfunction

    function automatic int block_of(input int a);
        int top;
        int r;
        int base;
        top  = dev_bytes() - 65536;
        base = (dev_bytes() >> 16) - 1;
        if (a < top) return a >> 16;
        r = a - top;
        if (r < 32768) return base;
        if (r < 40960) return base + 1;
        if (r < 49152) return base + 2;
        return base + 3;
    endfunction

    function automatic void wipe_block(input int idx);
        int base;
        int off;
        int len;
        int k;
        base = (dev_bytes() >> 16) - 1;
        if (idx >= MaxBlocks || !writable[idx]) return;
        if (idx < base) begin
            off = idx << 16;
            len = 65536;
        end else begin
            k   = (idx - base) & 3;
            off = dev_bytes() - 65536 + TopOff[k];
            len = TopLen[k];
        end
        for (int i = 0; i < len; i++) flash_img[off + i] = 8'hff;
        dirty_q = 1'b1;
    endfunction

    function automatic void back_to_read();
        mode  = MODE_READ;
        stage = 3'd0;
    endfunction

    function automatic void step_unlock();
        mode  = MODE_INDEX;
        stage = stage + 3'd1;
    endfunction

    function automatic void bus_write_cmd(input int a, input logic [7:0] d);
        logic [14:0] a15;
        logic [7:0]  nv;
        int          idx;
        a15 = a[14:0];
        if (mode == MODE_WRITE) begin
            idx = block_of(a);
            if (idx < MaxBlocks && writable[idx]) begin
                nv = flash_img[a] & d;
                if (nv != flash_img[a]) begin
                    flash_img[a] = nv;
                    dirty_q = 1'b1;
                end
            end
            back_to_read();
            return;
        end
        if (d == D_RESET) begin
            back_to_read();
            return;
        end
        case (stage)
            3'd0, 3'd3: if (a15 == UNLOCK_A1 && d == D_UNLOCK1) begin
                step_unlock();
                return;
            end
            3'd1, 3'd4: if (a15 == UNLOCK_A2 && d == D_UNLOCK2) begin
                step_unlock();
                return;
            end
            3'd2: if (a15 == UNLOCK_A1) begin
                if (d == D_ERASE || d == D_PROTECT) begin
                    step_unlock();
                    return;
                end
                if (d == D_READID) begin
                    mode = MODE_READID;
                    return;
                end
                if (d == D_PROGRAM) begin
                    mode = MODE_WRITE;
                    return;
                end
            end
            3'd5: begin
                if (a15 == UNLOCK_A1 && d == D_CHIP) begin
                    for (int i = 0; i < (dev_bytes() >> 16) + 3; i++) wipe_block(i);
                end else if (d == D_SECTOR) begin
                    wipe_block(block_of(a));
                end else if (d == D_PROTECT) begin
                    idx = block_of(a);
                    if (idx < MaxBlocks && writable[idx]) begin
                        writable[idx] = 1'b0;
                        dirty_q = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        back_to_read();
    endfunction

    function automatic access_result_t predict_access(input logic [31:0] word);
        access_result_t res;
        logic [1:0]     op;
        logic [20:0]    raw;
        logic [7:0]     d;
        int             a;
        op  = word[1:0];
        raw = word[22:2];
        d   = word[30:23];
        a   = int'(raw) & (dev_bytes() - 1);
        res.rd = 8'h00;
        if (op == OP_READ) begin
            if (mode == MODE_READID) begin
                case (raw[13:0])
                    14'd0:   res.rd = VENDOR_ID;
                    14'd1:   res.rd = (eff_sel() == 0) ? 8'hab :
                                      (eff_sel() == 1) ? 8'h2c : 8'h2f;
                    14'd2:   res.rd = 8'h02;
                    14'd3:   res.rd = 8'h80;
                    default: res.rd = 8'hff;
                endcase
            end else begin
                res.rd = flash_img[a];
            end
        end else if (op == OP_WRITE) begin
            bus_write_cmd(a, d);
        end else if (op == OP_PRELOAD) begin
            flash_img[a] = d;
        end
        res.dirty = dirty_q;
        return res;
    endfunction

    always @(posedge aclk) begin
        access_result_t exp_res;
        int errs;
        errs = 0;
        if (!aresetn) begin
            for (int i = 0; i < MaxBlocks; i++) writable[i] = 1'b1;
            mode     = MODE_READ;
            stage    = 3'd0;
            dirty_q  = 1'b0;
            size_sel = 2'd2;
            result_q.delete();
            fail_count <= 0;
        end else begin
            if (psel && penable && pwrite && paddr == 1'b0) size_sel = pwdata[1:0];
            if (s_tvalid && s_tready) result_q.push_back(predict_access(s_tdata));
            if (m_tvalid && m_tready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_tdata);
                    errs++;
                end else begin
                    exp_res = result_q.pop_front();
                    if (m_tdata[7:0] !== exp_res.rd) begin
                        $display("%0t: read_data mismatch, expected %h, actual %h",
                                 $time, exp_res.rd, m_tdata[7:0]);
                        errs++;
                    end
                    if (m_tdata[8] !== exp_res.dirty) begin
                        $display("%0t: dirty mismatch, expected %b, actual %b",
                                 $time, exp_res.dirty, m_tdata[8]);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
        pending <= result_q.size();
    end

endmodule

/* test/tb_nor_flash_command_controller_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NOR flash command controller testbench
// Drives directed and random bus accesses and unlock sequences through the
// request port, sweeps the size register and lets the checker judge results.
// ----------------------------------------------------------------------------
module tb_nor_flash_command_controller_unit;
    import nfcc_pkg::*;

    localparam int WatchdogLimit = 1000000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // opcode[1:0], bus_address[22:2], bus_data[30:23]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // read_data[7:0], dirty[8]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int idle_cycles;
    int dev_size;
    bit gaps_on;
    bit hold_off_req;
    int known_addrs [$];

    nor_flash_command_controller_unit DUT (.*);

    nfcc_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: random stalls per result, plus one long hold-off on request.
    initial begin
        int w;
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            w = gaps_on ? $urandom_range(0, 19) : 0;
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                w = 400;
            end
            if (w > 0) begin
                m_tready <= 1'b0;
                repeat (w) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WatchdogLimit) begin
            $display("tb_nor_flash_command_controller_unit NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_request(input logic [1:0] op, input logic [20:0] addr,
                                input logic [7:0] data);
        int gap;
        gap = gaps_on ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, data, addr, op};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic preload(input int phys, input logic [7:0] data);
        send_request(OP_PRELOAD, 21'(phys), data);
        known_addrs.push_back(phys & (dev_size - 1));
    endtask

    // A bus address whose byte in the array has been preloaded, with random
    // bits above the size in use.
    function automatic logic [20:0] known_addr();
        int phys;
        do phys = known_addrs[$urandom_range(0, known_addrs.size() - 1)];
        while (phys >= dev_size);
        return 21'(($urandom_range(0, MemBytes - 1) & ~(dev_size - 1)) | phys);
    endfunction

    function automatic logic [20:0] cmd_addr(input logic [14:0] a15);
        return {6'($urandom_range(0, 63)), a15};
    endfunction

    task automatic unlock3(input logic [7:0] cmd);
        send_request(OP_WRITE, cmd_addr(UNLOCK_A1), D_UNLOCK1);
        send_request(OP_WRITE, cmd_addr(UNLOCK_A2), D_UNLOCK2);
        send_request(OP_WRITE, cmd_addr(UNLOCK_A1), cmd);
    endtask

    task automatic unlock6(input logic [7:0] first, input logic [20:0] addr,
                           input logic [7:0] last);
        unlock3(first);
        send_request(OP_WRITE, cmd_addr(UNLOCK_A1), D_UNLOCK1);
        send_request(OP_WRITE, cmd_addr(UNLOCK_A2), D_UNLOCK2);
        send_request(OP_WRITE, addr, last);
    endtask

    task automatic read_ids();
        unlock3(D_READID);
        for (int i = 0; i < 5; i++) send_request(OP_READ, 21'(i), 8'h00);
        send_request(OP_READ, known_addr(), 8'h00);
        send_request(OP_WRITE, known_addr(), D_RESET);
    endtask

    // A trailing read drains the array port, so a slow erase is finished
    // once its result has come back.
    task automatic drain();
        send_request(OP_READ, known_addr(), 8'h00);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic write_size(input logic [1:0] sel);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= 1'b0;
        pwdata  <= {30'd0, sel};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        dev_size = 524288 << ((sel == 2'd3) ? 2 : int'(sel));
    endtask

    task automatic random_item();
        int pick;
        int k;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            preload($urandom_range(0, MemBytes - 1), 8'($urandom));
        end else if (pick < 38) begin
            send_request(OP_READ, known_addr(), 8'($urandom));
        end else if (pick < 60) begin
            unlock3(D_PROGRAM);
            send_request(OP_WRITE, known_addr(), 8'($urandom));
        end else if (pick < 65) begin
            read_ids();
        end else if (pick < 66) begin
            unlock6(D_ERASE, known_addr(), D_SECTOR);
        end else if (pick < 69) begin
            unlock6(($urandom_range(0, 1) != 0) ? D_PROTECT : D_ERASE,
                    known_addr(), D_PROTECT);
        end else if (pick < 72) begin
            send_request(OP_NOP, known_addr(), 8'($urandom));
        end else if (pick < 82) begin
            // Broken sequence: a correct prefix, then a random write.
            k = $urandom_range(0, 4);
            if (k > 0) send_request(OP_WRITE, cmd_addr(UNLOCK_A1), D_UNLOCK1);
            if (k > 1) send_request(OP_WRITE, cmd_addr(UNLOCK_A2), D_UNLOCK2);
            if (k > 2) send_request(OP_WRITE, cmd_addr(UNLOCK_A1), D_ERASE);
            if (k > 3) send_request(OP_WRITE, cmd_addr(UNLOCK_A1), D_UNLOCK1);
            send_request(OP_WRITE, known_addr(), 8'($urandom));
        end else begin
            send_request(OP_WRITE, known_addr(), 8'($urandom));
        end
    endtask

    initial begin
        logic [1:0] sizes [5] = '{2'd0, 2'd1, 2'd3, 2'd2, 2'd0};
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = 1'b0;
        pwdata       = '0;
        gaps_on      = 1'b1;
        hold_off_req = 1'b0;
        dev_size     = MemBytes;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Every alias of the command addresses holds a known byte, so an
        // armed program at those addresses never reads an unwritten byte.
        for (int k = 0; k < 64; k++) begin
            preload(32'h5555 + k * 32768, 8'($urandom));
            preload(32'h2aaa + k * 32768, 8'($urandom));
        end
        for (int i = 0; i < 5; i++) preload(i, 8'hff);
        preload(MemBytes - 1, 8'h00);
        preload(65536 * 31, 8'h5a);
        send_request(OP_READ, 21'h1fffff, 8'h00);
        send_request(OP_READ, 21'h0, 8'h00);
        read_ids();
        unlock3(D_PROGRAM);
        send_request(OP_WRITE, 21'h0, 8'h0f);
        send_request(OP_READ, 21'h0, 8'h00);
        unlock3(D_PROGRAM);
        send_request(OP_WRITE, 21'h1fffff, 8'hff);
        send_request(OP_WRITE, cmd_addr(UNLOCK_A1), D_UNLOCK1);
        send_request(OP_WRITE, cmd_addr(UNLOCK_A2), D_RESET);
        send_request(OP_NOP, 21'h1fffff, 8'hff);
        // Protecting most blocks keeps later erases short.
        for (int b = 1; b <= 30; b++) unlock6(D_PROTECT, 21'(b * 65536), D_PROTECT);
        unlock6(D_ERASE, 21'(65536 * 31), D_SECTOR);
        unlock6(D_ERASE, 21'(65536 * 2), D_SECTOR);
        unlock6(D_ERASE, cmd_addr(UNLOCK_A1), D_CHIP);
        send_request(OP_READ, 21'(65536 * 31), 8'h00);
        send_request(OP_READ, 21'h1fffff, 8'h00);
        hold_off_req = 1'b1;
        repeat (60) random_item();

        for (int p = 0; p < 5; p++) begin
            drain();
            write_size(sizes[p]);
            gaps_on = (p != 2);
            for (int i = 0; i < 100; i++) random_item();
        end
        drain();
        if (fail_count == 0) begin
            $display("tb_nor_flash_command_controller_unit OK");
        end else begin
            $display("tb_nor_flash_command_controller_unit NOT OK");
        end
        $finish;
    end

endmodule
